// File: hdl/ogd_pkg.sv
// Shared types, codes and helpers for the Ogg page deframer.
// Used by the top level, ogd_engine, ogd_outq and the bench; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package ogd_pkg;

  localparam int unsigned MaxSegments = 255;
  localparam logic [31:0] CrcPoly     = 32'h04c11db7;
  localparam logic [8:0]  FixedLen    = 9'd27;
  localparam logic [8:0]  NoLace      = 9'd256;

  localparam logic [1:0] KIND_BODY = 2'd0;
  localparam logic [1:0] KIND_PAGE = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_CAPTURE   = 4'd1;
  localparam logic [3:0] ST_VERSION   = 4'd2;
  localparam logic [3:0] ST_CRC       = 4'd3;
  localparam logic [3:0] ST_BOS       = 4'd4;
  localparam logic [3:0] ST_SERIAL    = 4'd5;
  localparam logic [3:0] ST_SEQUENCE  = 4'd6;
  localparam logic [3:0] ST_CONTINUE  = 4'd7;
  localparam logic [3:0] ST_GRANULE   = 4'd8;
  localparam logic [3:0] ST_FIRST     = 4'd9;
  localparam logic [3:0] ST_EOS_OPEN  = 4'd10;
  localparam logic [3:0] ST_TRUNCATED = 4'd11;
  localparam logic [3:0] ST_NO_EOS    = 4'd12;
  localparam logic [3:0] ST_CLEAN_END = 4'd13;
  localparam logic [3:0] ST_FAILED    = 4'd14;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic        packet_end;
    logic [3:0]  status;
    logic [63:0] granule;
    logic [31:0] serial;
    logic [31:0] sequence_res;
    logic [2:0]  page_flags;
    logic [7:0]  segment_count;
    logic [15:0] body_length;
    logic        last;
  } result_t;

  typedef struct packed {
    logic    push0;
    logic    push1;
    result_t r0;
    result_t r1;
  } push_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {b, 24'h0};
    for (int k = 0; k < 8; k++) begin
      c = c[31] ? ({c[30:0], 1'b0} ^ CrcPoly) : {c[30:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [7:0] capture_byte(input logic [1:0] idx);
    logic [7:0] v;
    case (idx)
      2'd0: v = 8'h4f;
      2'd1: v = 8'h67;
      2'd2: v = 8'h67;
      default: v = 8'h53;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: hdl/ogg_page_deframer_top.sv
// Ogg page deframer: the top level that joins input queue, parser and result queue.
// Depends on ogd_pkg, ogd_inq, ogd_engine and ogd_outq.
//
// Usage: feed the Ogg stream one byte per request on the in_ channel; a request
// with in_end_of_input high closes the stream and its byte is ignored.
// Every body byte comes back as a kind 0 result with its packet-end mark, the
// last byte of each page is followed by a kind 1 page verdict, and an end mark
// gives a kind 2 verdict. Header and lacing bytes give no result except the
// byte that completes an empty page or a failed capture.
// An accepted request is registered in the input queue, and its first result in the
// result queue, before that result reaches out_. One byte is taken every cycle while the
// four-entry result queue has room; a byte that closes a page yields two results.
// After reset the block waits for a page header, with no stream open.
// A stalled out_ channel fills the result queue and then the two-entry input
// queue, after which in_stall rises; nothing is lost or reordered.
// After any error data bytes are dropped until reset.
`timescale 1ns / 1ps
`default_nettype none
module ogg_page_deframer_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_end_of_input,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_payload_byte,
  output logic             out_packet_end,
  output logic [3:0]       out_status,
  output logic [63:0]      out_granule,
  output logic [31:0]      out_serial,
  output logic [31:0]      out_sequence_res,
  output logic [2:0]       out_page_flags,
  output logic [7:0]       out_segment_count,
  output logic [15:0]      out_body_length,
  output logic             out_last
);

  logic             item_valid, item_eoi, item_take, room;
  logic [7:0]       item_byte;
  ogd_pkg::push_t   push;
  ogd_pkg::result_t head;

  ogd_inq u_inq (
    .clk, .rst_n, .in_valid, .in_stall, .in_data_byte, .in_end_of_input,
    .item_valid, .item_byte, .item_eoi, .item_take
  );

  ogd_engine u_engine (
    .clk, .rst_n, .item_valid, .item_byte, .item_eoi, .item_take, .room, .push
  );

  ogd_outq u_outq (
    .clk, .rst_n, .push, .room, .out_valid, .out_stall, .head
  );

  assign out_kind          = head.kind;
  assign out_payload_byte  = head.payload_byte;
  assign out_packet_end    = head.packet_end;
  assign out_status        = head.status;
  assign out_granule       = head.granule;
  assign out_serial        = head.serial;
  assign out_sequence_res  = head.sequence_res;
  assign out_page_flags    = head.page_flags;
  assign out_segment_count = head.segment_count;
  assign out_body_length   = head.body_length;
  assign out_last          = head.last;

  a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
    push.push1 |-> push.push0)
    else $error("second result pushed without a first");

  a_body_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == ogd_pkg::KIND_BODY) |-> (out_status == ogd_pkg::ST_OK))
    else $error("body byte carries a status");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != ogd_pkg::KIND_BODY) |-> out_last)
    else $error("verdict not marked last");

  a_take_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.push0 || push.push1) |-> $past(room) || item_take)
    else $error("result pushed without queue room");

endmodule
`default_nettype wire

// File: hdl/ogd_inq.sv
// Input side: two-entry queue that takes stream items off the input channel.
// Depends on nothing; it does not use ogd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ogd_inq (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_end_of_input,
  output logic            item_valid,
  output logic [7:0]      item_byte,
  output logic            item_eoi,
  input  wire logic       item_take
);

  logic [8:0] q_r [2];
  logic       wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign in_stall   = (cnt_r == 2'd2);
  assign push       = in_valid && !in_stall;
  assign item_valid = (cnt_r != 2'd0);
  assign item_byte  = q_r[rptr_r][7:0];
  assign item_eoi   = q_r[rptr_r][8];

  always_comb begin
    wptr_nxt = wptr_r ^ push;
    rptr_nxt = rptr_r ^ item_take;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, item_take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= {in_end_of_input, in_data_byte};
    end
  end

endmodule
`default_nettype wire

// File: hdl/ogd_engine.sv
// Page parser: header capture, CRC, lacing store, body marks and page verdicts.
// Depends on ogd_pkg; emits up to two results per item to the output queue.
`timescale 1ns / 1ps
`default_nettype none
module ogd_engine (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       item_valid,
  input  wire logic [7:0] item_byte,
  input  wire logic       item_eoi,
  output logic            item_take,
  input  wire logic       room,
  output ogd_pkg::push_t  push
);

  logic [8:0]  hpos_r, hpos_nxt;
  logic [31:0] crc_r, crc_nxt, scrc_r, scrc_nxt;
  logic [2:0]  flags_r, flags_nxt;
  logic [63:0] gran_r, gran_nxt;
  logic [31:0] ser_r, ser_nxt, seq_r, seq_nxt;
  logic [7:0]  segs_r, segs_nxt;
  logic [15:0] left_r, left_nxt, total_r, total_nxt;
  logic [8:0]  lcl_r, lcl_nxt;
  logic [31:0] sserial_r, sserial_nxt, expseq_r, expseq_nxt;
  logic        sopen_r, sopen_nxt, sdone_r, sdone_nxt;
  logic        popen_r, popen_nxt, failed_r, failed_nxt;
  logic [3:0]  early_r, early_nxt;
  logic [7:0]  cursor_r, cursor_nxt, wptr_r, wptr_nxt, lleft_r, lleft_nxt;
  logic        full_r, full_nxt;

  // Only nonzero lacing values are stored; zero values never carry a byte.
  logic [7:0]  lace_mem [ogd_pkg::MaxSegments];
  logic [7:0]  mem_q_r;
  logic        mem_we;

  logic        do_judge, pend, first, ends_open;
  logic [3:0]  st, vst;
  logic [8:0]  off6, off14, off18, off22, idx;
  logic [7:0]  b;
  logic [1:0]  nres;
  logic        body_res;

  assign item_take = item_valid && room;
  assign b         = item_byte;

  always_comb begin
    hpos_nxt = hpos_r;   crc_nxt = crc_r;     scrc_nxt = scrc_r;
    flags_nxt = flags_r; gran_nxt = gran_r;   ser_nxt = ser_r;
    seq_nxt = seq_r;     segs_nxt = segs_r;   left_nxt = left_r;
    total_nxt = total_r; lcl_nxt = lcl_r;     sserial_nxt = sserial_r;
    expseq_nxt = expseq_r; sopen_nxt = sopen_r; sdone_nxt = sdone_r;
    popen_nxt = popen_r; failed_nxt = failed_r; early_nxt = early_r;
    cursor_nxt = cursor_r; wptr_nxt = wptr_r; lleft_nxt = lleft_r;
    full_nxt = full_r;
    mem_we = 1'b0;  do_judge = 1'b0; pend = 1'b0; first = 1'b0;
    st = ogd_pkg::ST_OK; vst = ogd_pkg::ST_OK; nres = 2'd0; body_res = 1'b0;
    off6  = hpos_r - 9'd6;
    off14 = hpos_r - 9'd14;
    off18 = hpos_r - 9'd18;
    off22 = hpos_r - 9'd22;
    idx   = hpos_r - ogd_pkg::FixedLen;
    ends_open = 1'b0;

    if (item_take) begin
      if (item_eoi) begin
        nres = 2'd1;
        if (failed_r) begin
          vst = ogd_pkg::ST_FAILED;
        end else if (hpos_r != 9'd0) begin
          vst = ogd_pkg::ST_TRUNCATED;
          failed_nxt = 1'b1;
        end else if (sopen_r && sdone_r) begin
          vst = ogd_pkg::ST_CLEAN_END;
        end else begin
          vst = ogd_pkg::ST_NO_EOS;
          failed_nxt = 1'b1;
        end
      end else if (!failed_r) begin
        if (hpos_r < ogd_pkg::FixedLen) begin
          if (hpos_r == 9'd0) begin
            crc_nxt = 32'h0; early_nxt = 4'd0; gran_nxt = 64'h0;
            ser_nxt = 32'h0; seq_nxt = 32'h0; scrc_nxt = 32'h0;
            flags_nxt = 3'd0; segs_nxt = 8'd0; left_nxt = 16'd0; total_nxt = 16'd0;
          end
          crc_nxt = ogd_pkg::crc_byte(crc_nxt,
                      (hpos_r >= 9'd22 && hpos_r < 9'd26) ? 8'h00 : b);
          if (hpos_r < 9'd4) begin
            if (b != ogd_pkg::capture_byte(hpos_r[1:0]) && early_nxt == 4'd0)
              early_nxt = ogd_pkg::ST_CAPTURE;
          end else if (hpos_r == 9'd4) begin
            if (b != 8'h00 && early_nxt == 4'd0) early_nxt = ogd_pkg::ST_VERSION;
          end else if (hpos_r == 9'd5) begin
            flags_nxt = b[2:0];
            if (b[7:3] != 5'd0 && early_nxt == 4'd0) early_nxt = ogd_pkg::ST_VERSION;
          end else if (hpos_r < 9'd14) begin
            gran_nxt[{off6[2:0], 3'b000} +: 8] = b;
          end else if (hpos_r < 9'd18) begin
            ser_nxt[{off14[1:0], 3'b000} +: 8] = b;
          end else if (hpos_r < 9'd22) begin
            seq_nxt[{off18[1:0], 3'b000} +: 8] = b;
          end else if (hpos_r < 9'd26) begin
            scrc_nxt[{off22[1:0], 3'b000} +: 8] = b;
          end
          hpos_nxt = hpos_r + 9'd1;
          if (hpos_r == 9'd26) begin
            if (early_nxt == ogd_pkg::ST_CAPTURE) begin
              failed_nxt = 1'b1;
              hpos_nxt = 9'd0;
              nres = 2'd1;
              vst = ogd_pkg::ST_CAPTURE;
            end else begin
              segs_nxt = b;
              lcl_nxt = ogd_pkg::NoLace;
              cursor_nxt = 8'd0; wptr_nxt = 8'd0; lleft_nxt = 8'd0;
              hpos_nxt = ogd_pkg::FixedLen;
              if (b == 8'd0) do_judge = 1'b1;
            end
          end
        end else if (idx < {1'b0, segs_r}) begin
          crc_nxt = ogd_pkg::crc_byte(crc_r, b);
          if (b != 8'd0) begin
            mem_we = 1'b1;
            wptr_nxt = wptr_r + 8'd1;
          end
          left_nxt  = left_r + {8'd0, b};
          total_nxt = total_r + {8'd0, b};
          if (b != 8'hff) lcl_nxt = idx;
          hpos_nxt = hpos_r + 9'd1;
          if (idx + 9'd1 == {1'b0, segs_r} && left_nxt == 16'd0) do_judge = 1'b1;
        end else begin
          crc_nxt = ogd_pkg::crc_byte(crc_r, b);
          body_res = 1'b1;
          nres = 2'd1;
          if (lleft_r == 8'd0 && cursor_r < wptr_r) begin
            lleft_nxt  = mem_q_r;
            full_nxt   = (mem_q_r == 8'hff);
            cursor_nxt = cursor_r + 8'd1;
          end
          if (lleft_nxt != 8'd0) begin
            lleft_nxt = lleft_nxt - 8'd1;
            if (lleft_nxt == 8'd0 && !full_nxt) pend = 1'b1;
          end
          if (left_r != 16'd0) left_nxt = left_r - 16'd1;
          if (left_nxt == 16'd0) do_judge = 1'b1;
        end
      end
    end

    if (do_judge) begin
      nres = body_res ? 2'd2 : 2'd1;
      ends_open = (segs_nxt != 8'd0) && (lcl_nxt != ({1'b0, segs_nxt} - 9'd1));
      if (early_nxt != 4'd0) begin
        st = early_nxt;
      end else if (crc_nxt != scrc_nxt) begin
        st = ogd_pkg::ST_CRC;
      end else begin
        if (!sopen_r || sdone_r) begin
          if (flags_nxt != 3'd2 || seq_nxt != 32'd0 || (sopen_r && ser_nxt == sserial_r)) begin
            st = ogd_pkg::ST_BOS;
          end else begin
            sopen_nxt = 1'b1;
            sdone_nxt = 1'b0;
            sserial_nxt = ser_nxt;
            expseq_nxt = 32'd0;
            first = 1'b1;
          end
        end else if (flags_nxt[1]) begin
          st = ogd_pkg::ST_BOS;
        end else if (ser_nxt != sserial_r) begin
          st = ogd_pkg::ST_SERIAL;
        end
        if (st == ogd_pkg::ST_OK) begin
          if (seq_nxt != expseq_nxt) st = ogd_pkg::ST_SEQUENCE;
          else expseq_nxt = expseq_nxt + 32'd1;
        end
        if (st == ogd_pkg::ST_OK && flags_nxt[0] != popen_r) st = ogd_pkg::ST_CONTINUE;
        if (st == ogd_pkg::ST_OK && first && (segs_nxt == 8'd0 || ends_open))
          st = ogd_pkg::ST_FIRST;
        if (st == ogd_pkg::ST_OK && lcl_nxt == ogd_pkg::NoLace && gran_nxt != '1)
          st = ogd_pkg::ST_GRANULE;
        if (st == ogd_pkg::ST_OK && flags_nxt[2] && ends_open) st = ogd_pkg::ST_EOS_OPEN;
        if (st == ogd_pkg::ST_OK) begin
          if (segs_nxt != 8'd0) popen_nxt = ends_open;
          if (flags_nxt[2]) sdone_nxt = 1'b1;
        end
      end
      if (st != ogd_pkg::ST_OK) failed_nxt = 1'b1;
      hpos_nxt = 9'd0;
      vst = st;
    end
  end

  // Result records: a body byte goes first, a verdict first or second.
  always_comb begin
    result_t_fill : begin
      ogd_pkg::result_t vr, br;
      br = '0;
      br.kind = ogd_pkg::KIND_BODY;
      br.payload_byte = b;
      br.packet_end = pend;
      br.last = (nres == 2'd1);
      vr = '0;
      vr.status = vst;
      vr.last = 1'b1;
      if (item_eoi) begin
        vr.kind = ogd_pkg::KIND_END;
      end else begin
        vr.kind = ogd_pkg::KIND_PAGE;
        vr.granule = gran_nxt;
        vr.serial = ser_nxt;
        vr.sequence_res = seq_nxt;
        vr.page_flags = flags_nxt;
        vr.segment_count = segs_nxt;
        vr.body_length = total_nxt;
      end
      push.push0 = (nres != 2'd0);
      push.push1 = (nres == 2'd2);
      push.r0 = body_res ? br : vr;
      push.r1 = vr;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      lace_mem[wptr_r] <= b;
    end
    if (mem_we && wptr_r == cursor_nxt) begin
      mem_q_r <= b;
    end else begin
      mem_q_r <= lace_mem[cursor_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hpos_r <= 9'd0; crc_r <= 32'd0; scrc_r <= 32'd0; flags_r <= 3'd0;
      gran_r <= 64'd0; ser_r <= 32'd0; seq_r <= 32'd0; segs_r <= 8'd0;
      left_r <= 16'd0; total_r <= 16'd0; lcl_r <= ogd_pkg::NoLace;
      sserial_r <= 32'd0; expseq_r <= 32'd0; sopen_r <= 1'b0; sdone_r <= 1'b0;
      popen_r <= 1'b0; failed_r <= 1'b0; early_r <= 4'd0;
      cursor_r <= 8'd0; wptr_r <= 8'd0; lleft_r <= 8'd0; full_r <= 1'b0;
    end else begin
      hpos_r <= hpos_nxt; crc_r <= crc_nxt; scrc_r <= scrc_nxt; flags_r <= flags_nxt;
      gran_r <= gran_nxt; ser_r <= ser_nxt; seq_r <= seq_nxt; segs_r <= segs_nxt;
      left_r <= left_nxt; total_r <= total_nxt; lcl_r <= lcl_nxt;
      sserial_r <= sserial_nxt; expseq_r <= expseq_nxt; sopen_r <= sopen_nxt;
      sdone_r <= sdone_nxt; popen_r <= popen_nxt; failed_r <= failed_nxt;
      early_r <= early_nxt; cursor_r <= cursor_nxt; wptr_r <= wptr_nxt;
      lleft_r <= lleft_nxt; full_r <= full_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hdl/ogd_outq.sv
// Output side: four-entry result queue, takes up to two results a cycle.
// Depends on ogd_pkg for the result record.
`timescale 1ns / 1ps
`default_nettype none
module ogd_outq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire ogd_pkg::push_t  push,
  output logic                 room,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output ogd_pkg::result_t     head
);

  ogd_pkg::result_t q_r [4];
  logic [1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       pop;

  assign out_valid = (cnt_r != 3'd0);
  assign pop       = out_valid && !out_stall;
  assign room      = (cnt_r <= 3'd2);
  assign head      = q_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r + {1'b0, push.push0} + {1'b0, push.push1};
    rptr_nxt = rptr_r + {1'b0, pop};
    cnt_nxt  = cnt_r + {2'd0, push.push0} + {2'd0, push.push1} - {2'd0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 2'd0;
      rptr_r <= 2'd0;
      cnt_r  <= 3'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.push0) begin
      q_r[wptr_r] <= push.r0;
    end
    if (push.push1) begin
      q_r[wptr_r + 2'd1] <= push.r1;
    end
  end

endmodule
`default_nettype wire

// File: bench/tb_ogg_page_deframer_top.sv
// Self-checking bench for ogg_page_deframer_top: builds Ogg pages and streams with their CRC,
// follows every accepted byte in a software copy of the deframer and checks every result.
// Depends on ogd_pkg and the deframer RTL.
`timescale 1ns / 1ps
module tb_ogg_page_deframer_top;

  localparam int StallLimit = 4000;
  localparam logic [31:0] Magic = 32'h4f676753;

  typedef struct {
    logic [7:0] d;
    logic       eoi;
    bit         drain;
  } req_t;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 0;
  logic        in_end_of_input = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [1:0]  out_kind;
  logic [7:0]  out_payload_byte;
  logic        out_packet_end;
  logic [3:0]  out_status;
  logic [63:0] out_granule;
  logic [31:0] out_serial;
  logic [31:0] out_sequence_res;
  logic [2:0]  out_page_flags;
  logic [7:0]  out_segment_count;
  logic [15:0] out_body_length;
  logic        out_last;

  ogg_page_deframer_top dut (.*);

  always #4 clk = ~clk;

  req_t             requests[$];
  ogd_pkg::result_t due_results[$];
  int               errors = 0;

  // Software copy of the deframer state.
  int unsigned hpos, body_left, body_total, lace_cur, lace_rem, last_done;
  logic [31:0] run_crc, got_crc, hser, hseq, str_serial, next_seq;
  logic [63:0] hgran;
  logic [2:0]  hflags;
  logic [7:0]  hseg;
  logic [3:0]  early;
  logic [7:0]  lace_mem[255];
  bit          str_open, str_done, pkt_open, dead;

  // Stream generator state.
  bit          g_open, g_any, g_pkt_open;
  logic [31:0] g_serial, g_seq;

  function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[31] ^ b[i];
      c = {c[30:0], 1'b0};
      if (fb) c = c ^ ogd_pkg::CrcPoly;
    end
    return c;
  endfunction

  task automatic emit(logic [1:0] kind, logic [7:0] pay, logic pend, logic [3:0] st,
                      bit page, logic lst);
    ogd_pkg::result_t r;
    r = '0;
    r.kind = kind;
    r.payload_byte = pay;
    r.packet_end = pend;
    r.status = st;
    if (page) begin
      r.granule = hgran;
      r.serial = hser;
      r.sequence_res = hseq;
      r.page_flags = hflags;
      r.segment_count = hseg;
      r.body_length = body_total[15:0];
    end
    r.last = lst;
    due_results.push_back(r);
  endtask

  task automatic page_verdict(output logic [3:0] st);
    bit first, ends_open;
    first = 0;
    st = ogd_pkg::ST_OK;
    ends_open = hseg != 0 && last_done != hseg - 1;
    if (early != ogd_pkg::ST_OK) st = early;
    else if (run_crc != got_crc) st = ogd_pkg::ST_CRC;
    else begin
      if (!str_open || str_done) begin
        if (hflags != 3'd2 || hseq != 0 || (str_open && hser == str_serial))
          st = ogd_pkg::ST_BOS;
        else begin
          str_open = 1;
          str_done = 0;
          str_serial = hser;
          next_seq = 0;
          first = 1;
        end
      end else if (hflags[1]) st = ogd_pkg::ST_BOS;
      else if (hser != str_serial) st = ogd_pkg::ST_SERIAL;
      if (st == ogd_pkg::ST_OK) begin
        if (hseq != next_seq) st = ogd_pkg::ST_SEQUENCE;
        else next_seq = next_seq + 1;
      end
      if (st == ogd_pkg::ST_OK && hflags[0] != pkt_open) st = ogd_pkg::ST_CONTINUE;
      if (st == ogd_pkg::ST_OK && first && (hseg == 0 || ends_open)) st = ogd_pkg::ST_FIRST;
      if (st == ogd_pkg::ST_OK && last_done == ogd_pkg::NoLace && hgran != '1)
        st = ogd_pkg::ST_GRANULE;
      if (st == ogd_pkg::ST_OK && hflags[2] && ends_open) st = ogd_pkg::ST_EOS_OPEN;
      if (st == ogd_pkg::ST_OK) begin
        if (hseg != 0) pkt_open = ends_open;
        if (hflags[2]) str_done = 1;
      end
    end
    if (st != ogd_pkg::ST_OK) dead = 1;
    hpos = 0;
  endtask

  task automatic track_byte(logic [7:0] d, logic eoi);
    logic [3:0] st;
    logic pend;
    int unsigned idx;
    if (eoi) begin
      if (dead) st = ogd_pkg::ST_FAILED;
      else if (hpos != 0) begin
        st = ogd_pkg::ST_TRUNCATED;
        dead = 1;
      end else if (str_open && str_done) st = ogd_pkg::ST_CLEAN_END;
      else begin
        st = ogd_pkg::ST_NO_EOS;
        dead = 1;
      end
      emit(ogd_pkg::KIND_END, 0, 0, st, 0, 1);
      return;
    end
    if (dead) return;
    if (hpos < ogd_pkg::FixedLen) begin
      if (hpos == 0) begin
        run_crc = 0; early = ogd_pkg::ST_OK; hgran = 0; hser = 0; hseq = 0; got_crc = 0;
        hflags = 0; hseg = 0; body_left = 0; body_total = 0;
      end
      run_crc = crc_step(run_crc, (hpos >= 22 && hpos < 26) ? 8'h00 : d);
      if (hpos < 4) begin
        if (d != Magic[31 - 8 * hpos -: 8] && early == ogd_pkg::ST_OK)
          early = ogd_pkg::ST_CAPTURE;
      end else if (hpos == 4) begin
        if (d != 0 && early == ogd_pkg::ST_OK) early = ogd_pkg::ST_VERSION;
      end else if (hpos == 5) begin
        hflags = d[2:0];
        if (d[7:3] != 0 && early == ogd_pkg::ST_OK) early = ogd_pkg::ST_VERSION;
      end else if (hpos < 14) hgran[8 * (hpos - 6) +: 8] = d;
      else if (hpos < 18) hser[8 * (hpos - 14) +: 8] = d;
      else if (hpos < 22) hseq[8 * (hpos - 18) +: 8] = d;
      else if (hpos < 26) got_crc[8 * (hpos - 22) +: 8] = d;
      else begin
        if (early == ogd_pkg::ST_CAPTURE) begin
          dead = 1;
          hpos = 0;
          emit(ogd_pkg::KIND_PAGE, 0, 0, ogd_pkg::ST_CAPTURE, 1, 1);
          return;
        end
        hseg = d;
        last_done = ogd_pkg::NoLace;
        lace_cur = 0;
        lace_rem = 0;
        hpos = ogd_pkg::FixedLen;
        if (d == 0) begin
          page_verdict(st);
          emit(ogd_pkg::KIND_PAGE, 0, 0, st, 1, 1);
        end
        return;
      end
      hpos++;
      return;
    end
    run_crc = crc_step(run_crc, d);
    idx = hpos - ogd_pkg::FixedLen;
    if (idx < hseg) begin
      lace_mem[idx] = d;
      body_left += d;
      body_total += d;
      if (d < 255) last_done = idx;
      hpos++;
      if (idx + 1 == hseg && body_left == 0) begin
        page_verdict(st);
        emit(ogd_pkg::KIND_PAGE, 0, 0, st, 1, 1);
      end
      return;
    end
    // Body byte: walk the lacing table to find where this byte falls.
    pend = 0;
    while (lace_rem == 0 && lace_cur < hseg) begin
      lace_rem = lace_mem[lace_cur];
      lace_cur++;
    end
    if (lace_rem != 0) begin
      lace_rem--;
      if (lace_rem == 0 && lace_cur != 0 && lace_mem[lace_cur - 1] < 255) pend = 1;
    end
    if (body_left != 0) body_left--;
    emit(ogd_pkg::KIND_BODY, d, pend, ogd_pkg::ST_OK, 0, body_left != 0);
    if (body_left == 0) begin
      page_verdict(st);
      emit(ogd_pkg::KIND_PAGE, 0, 0, st, 1, 1);
    end
  endtask

  task automatic push_req(logic [7:0] d, logic eoi, bit drain);
    req_t r;
    r.d = d;
    r.eoi = eoi;
    r.drain = drain;
    requests.push_back(r);
  endtask

  // Builds one page that keeps the stream legal, unless a byte is flipped or it is cut short.
  // keep < 0 sends the whole page, otherwise only its first keep bytes.
  task automatic add_page(int nseg, bit eos, bit drain, int lmax, int flip_pos, bit fix_crc,
                          int keep);
    logic [7:0]  pg[$];
    logic [7:0]  laces[$];
    logic [63:0] gran;
    logic [31:0] ser, seq, c;
    logic [2:0]  flags;
    bit          fresh, any_done;
    int          r, sum;
    fresh = !g_open;
    if (fresh && nseg == 0) nseg = 1;
    if (eos && nseg == 0 && g_pkt_open) nseg = 1;
    any_done = 0;
    sum = 0;
    for (int i = 0; i < nseg; i++) begin
      r = $urandom % 16;
      if (r == 0) laces.push_back(8'd255);
      else if (r == 1 || lmax == 0) laces.push_back(8'd0);
      else laces.push_back(8'($urandom_range(1, lmax)));
      if ((fresh || eos) && i == nseg - 1 && laces[i] == 255)
        laces[i] = 8'($urandom_range(0, lmax > 254 ? 254 : lmax));
      if (laces[i] < 255) any_done = 1;
      sum += laces[i];
    end
    if (!any_done) gran = '1;
    else begin
      r = $urandom % 8;
      gran = (r == 0) ? 64'd0 : (r == 1) ? '1 : {$urandom, $urandom};
    end
    if (fresh) begin
      ser = $urandom;
      if (g_any && ser == g_serial) ser = ~ser;
      seq = 0;
      flags = 3'b010;
    end else begin
      ser = g_serial;
      seq = g_seq;
      flags = {eos, 1'b0, g_pkt_open};
    end
    for (int i = 0; i < 4; i++) pg.push_back(Magic[31 - 8 * i -: 8]);
    pg.push_back(8'd0);
    pg.push_back({5'd0, flags});
    for (int i = 0; i < 8; i++) pg.push_back(gran[8 * i +: 8]);
    for (int i = 0; i < 4; i++) pg.push_back(ser[8 * i +: 8]);
    for (int i = 0; i < 4; i++) pg.push_back(seq[8 * i +: 8]);
    for (int i = 0; i < 4; i++) pg.push_back(8'd0);
    pg.push_back(8'(nseg));
    foreach (laces[i]) pg.push_back(laces[i]);
    for (int i = 0; i < sum; i++) pg.push_back(8'($urandom));
    if (flip_pos >= pg.size()) flip_pos = pg.size() - 1;
    if (flip_pos >= 0 && fix_crc) pg[flip_pos] ^= 8'($urandom_range(1, 255));
    c = 0;
    foreach (pg[i]) c = crc_step(c, (i >= 22 && i < 26) ? 8'd0 : pg[i]);
    for (int i = 0; i < 4; i++) pg[22 + i] = c[8 * i +: 8];
    if (flip_pos >= 0 && !fix_crc) pg[flip_pos] ^= 8'($urandom_range(1, 255));
    if (keep < 0 || keep > pg.size()) keep = pg.size();
    for (int i = 0; i < keep; i++) push_req(pg[i], 0, drain && i == 0);
    if (nseg != 0) g_pkt_open = laces[nseg - 1] == 255;
    if (fresh) begin
      g_open = 1;
      g_any = 1;
      g_serial = ser;
      g_seq = 1;
    end else g_seq = g_seq + 1;
    if (eos) g_open = 0;
  endtask

  initial begin
    int n;
    hpos = 0; body_left = 0; body_total = 0; lace_cur = 0; lace_rem = 0;
    last_done = ogd_pkg::NoLace; run_crc = 0; got_crc = 0; hser = 0; hseq = 0; hgran = 0;
    hflags = 0; hseg = 0; early = ogd_pkg::ST_OK; str_serial = 0; next_seq = 0;
    str_open = 0; str_done = 0; pkt_open = 0; dead = 0;
    g_open = 0; g_any = 0; g_pkt_open = 0; g_serial = 0; g_seq = 0;

    // Directed: empty packet, zero-segment page, long laces, full table, chained streams.
    add_page(1, 0, 0, 0, -1, 1, -1);
    add_page(0, 0, 0, 20, -1, 1, -1);
    add_page(3, 0, 0, 255, -1, 1, -1);
    add_page(255, 0, 0, 3, -1, 1, -1);
    add_page(2, 1, 0, 20, -1, 1, -1);
    push_req(8'($urandom), 1, 0);
    add_page(1, 0, 0, 20, -1, 1, -1);
    add_page(4, 1, 1, 20, -1, 1, -1);
    push_req(8'($urandom), 1, 0);

    while (requests.size() < 2000) begin
      n = ($urandom % 32 == 0) ? $urandom_range(100, 255) : $urandom_range(0, 8);
      add_page(n, $urandom % 6 == 0, $urandom % 20 == 0,
               n > 8 ? 4 : ($urandom % 4 == 0 ? 255 : 20), -1, 1, -1);
      if (!g_open && $urandom % 3 == 0) push_req(8'($urandom), 1, 0);
    end

    // One fault at the end, since any error is sticky until reset.
    if (!g_open) add_page(2, 0, 0, 20, -1, 1, -1);
    case ($urandom_range(0, 3))
      0: add_page($urandom_range(0, 6), $urandom % 2, 1, 20, $urandom_range(0, 27), 1, -1);
      1: add_page($urandom_range(0, 6), 0, 1, 20, $urandom_range(0, 40), 0, -1);
      2: begin
        add_page(3, 0, 1, 20, -1, 1, $urandom_range(1, 40));
        push_req(8'($urandom), 1, 0);
      end
      default: push_req(8'($urandom), 1, 1);
    endcase
    for (int i = 0; i < 5; i++) push_req(8'($urandom), 0, 0);
    push_req(8'($urandom), 1, 0);
    push_req(8'($urandom), 1, 0);

    repeat (6) @(posedge clk);
    rst_n <= 1;
    while (requests.size() != 0 || in_valid || due_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // Sender: one request at a time from the queue, with a random gap before each.
  int unsigned in_gap = 0, in_count = 0;
  bit in_steady = 0;
  always @(posedge clk) begin
    logic offer;
    req_t nxt;
    if (!rst_n) begin
      in_valid <= 0;
    end else begin
      offer = in_valid;
      if (in_valid && !in_stall) begin
        track_byte(in_data_byte, in_end_of_input);
        offer = 0;
        in_count++;
      end
      if (!offer) begin
        if (in_gap > 0) in_gap--;
        else if (requests.size() > 0 && (!requests[0].drain || due_results.size() == 0)) begin
          nxt = requests.pop_front();
          in_data_byte <= nxt.d;
          in_end_of_input <= nxt.eoi;
          offer = 1;
          if (in_count % 200 == 0) in_steady = ($urandom % 3 == 0);
          in_gap = in_steady ? 0 : $urandom_range(0, 16);
        end
      end
      in_valid <= offer;
    end
  end

  function automatic void check_field(string name, logic [63:0] exp, logic [63:0] act);
    if (exp !== act) begin
      $error("%s: expected %0h, got %0h", name, exp, act);
      errors++;
    end
  endfunction

  // Receiver: checks each result and stalls at random, once for a long stretch.
  int unsigned out_hold = 0, out_count = 0;
  bit out_steady = 0;
  always @(posedge clk) begin
    int unsigned hold;
    ogd_pkg::result_t e;
    if (!rst_n) begin
      out_stall <= 0;
    end else begin
      hold = out_hold;
      if (out_valid && !out_stall) begin
        out_count++;
        if (due_results.size() == 0) begin
          $error("result with nothing expected: kind %0d status %0d", out_kind, out_status);
          errors++;
        end else begin
          e = due_results.pop_front();
          check_field("kind", e.kind, out_kind);
          check_field("payload_byte", e.payload_byte, out_payload_byte);
          check_field("packet_end", e.packet_end, out_packet_end);
          check_field("status", e.status, out_status);
          check_field("granule", e.granule, out_granule);
          check_field("serial", e.serial, out_serial);
          check_field("sequence_res", e.sequence_res, out_sequence_res);
          check_field("page_flags", e.page_flags, out_page_flags);
          check_field("segment_count", e.segment_count, out_segment_count);
          check_field("body_length", e.body_length, out_body_length);
          check_field("last", e.last, out_last);
        end
        if (out_count % 150 == 0) out_steady = ($urandom % 3 == 0);
        hold = out_steady ? 0 : $urandom_range(0, 16);
        if (out_count == 300) hold = 400;
      end else if (hold > 0) hold--;
      out_hold = hold;
      out_stall <= hold > 0;
    end
  end

  int unsigned quiet = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else if (quiet == StallLimit) begin
      $display("Verification failed");
      $finish;
    end else quiet <= quiet + 1;
  end

endmodule
